[hw/rtl/ddq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA descriptor queue pair package
// Shared request and status codes, controller states and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ddq_pkg;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;

    // Low size bits that must be zero for a 32 KiB multiple.
    localparam int PAGE_GRAN_BITS = 15;
    // Low offset bits that must be zero for 4-byte alignment.
    localparam int ALIGN_BITS     = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FILL  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_PEND_FULL = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SIZE_ZERO = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_SIZE_GRAN = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ALIGN     = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_RESP
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fill_step;
        logic respond;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic is_fill;
        logic fill_done;
        logic out_free;
    } ctrl_sts_t;

endpackage
`default_nettype wire

[hw/rtl/ddq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA descriptor queue controller
// Sequences each request word through execute, fill (fill requests only) and response phases.
// ----------------------------------------------------------------------------
module ddq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ddq_pkg::ctrl_sts_t sts,
    output ddq_pkg::ctrl_cmd_t     cmd,
    output logic                   in_ready
);

    ddq_pkg::state_t state_reg;
    ddq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddq_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ddq_pkg::S_IDLE: begin
                if (sts.in_valid) begin
                    state_next = ddq_pkg::S_EXEC;
                end
            end
            ddq_pkg::S_EXEC: begin
                state_next = sts.is_fill ? ddq_pkg::S_FILL : ddq_pkg::S_RESP;
            end
            ddq_pkg::S_FILL: begin
                if (sts.fill_done) begin
                    state_next = ddq_pkg::S_RESP;
                end
            end
            ddq_pkg::S_RESP: begin
                // A new word may be taken in the same cycle the result leaves.
                if (sts.out_free) begin
                    state_next = sts.in_valid ? ddq_pkg::S_EXEC : ddq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ddq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready      = 1'b0;
        cmd.exec      = 1'b0;
        cmd.fill_step = 1'b0;
        cmd.respond   = 1'b0;
        case (state_reg)
            ddq_pkg::S_IDLE: begin
                in_ready = 1'b1;
            end
            ddq_pkg::S_EXEC: begin
                cmd.exec = 1'b1;
            end
            ddq_pkg::S_FILL: begin
                cmd.fill_step = !sts.fill_done;
            end
            ddq_pkg::S_RESP: begin
                in_ready    = sts.out_free;
                cmd.respond = sts.out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
        cmd.capture = in_ready && sts.in_valid;
    end

endmodule
`default_nettype wire

[hw/rtl/ddq_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA descriptor queue datapath
// Descriptor memories, queue pointers, push validation and result register.
// ----------------------------------------------------------------------------
module ddq_datapath #(
    parameter int PENDING_DEPTH  = 16,
    parameter int DONE_DEPTH     = 32,
    parameter int BYTE_ADDR_BITS = 36,
    parameter int PCW            = $clog2(PENDING_DEPTH + 1),
    parameter int DCW            = $clog2(DONE_DEPTH + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ddq_pkg::ctrl_cmd_t           cmd,
    output ddq_pkg::ctrl_sts_t                sts,
    input  wire logic                         in_valid,
    input  wire logic [ddq_pkg::REQ_W-1:0]    in_req,
    input  wire logic [BYTE_ADDR_BITS-1:0]    in_offset,
    input  wire logic [BYTE_ADDR_BITS-1:0]    in_size,
    input  wire logic                         cfg_we,
    input  wire logic [BYTE_ADDR_BITS-1:0]    cfg_wdata,
    output logic                              out_valid,
    input  wire logic                         out_ready_in,
    output logic [ddq_pkg::STATUS_W-1:0]      out_status,
    output logic [BYTE_ADDR_BITS-1:0]         out_offset,
    output logic [BYTE_ADDR_BITS-1:0]         out_size,
    output logic                              out_desc_ready,
    output logic [PCW-1:0]                    out_transfer_free,
    output logic [DCW-1:0]                    out_ready_count
);

    localparam int A   = BYTE_ADDR_BITS;
    localparam int PAW = $clog2(PENDING_DEPTH);
    localparam int DAW = $clog2(DONE_DEPTH);

    // Memories hold {size, offset}.
    logic [2*A-1:0] pend_mem [PENDING_DEPTH];
    logic [2*A-1:0] done_mem [DONE_DEPTH];

    logic [ddq_pkg::REQ_W-1:0]    req_reg;
    logic [A-1:0]                 off_reg;
    logic [A-1:0]                 size_reg;
    logic [A-1:0]                 buf_size_reg;
    logic [ddq_pkg::STATUS_W-1:0] push_st_reg, push_st_next;

    logic [PAW-1:0] pend_head_reg, pend_head_next;
    logic [PAW-1:0] pend_tail_reg, pend_tail_next;
    logic [PCW-1:0] pend_count_reg, pend_count_next;
    logic [DAW-1:0] done_head_reg, done_head_next;
    logic [DAW-1:0] done_tail_reg, done_tail_next;
    logic [DCW-1:0] done_count_reg, done_count_next;

    logic [2*A-1:0] pend_rd_reg;
    logic [2*A-1:0] done_rd_reg;

    logic                         m_valid_reg, m_valid_next;
    logic [ddq_pkg::STATUS_W-1:0] m_status_reg;
    logic [A-1:0]                 m_offset_reg;
    logic [A-1:0]                 m_size_reg;
    logic                         m_desc_ready_reg;
    logic [PCW-1:0]               m_free_reg;
    logic [DCW-1:0]               m_count_reg;

    logic                         pend_we;
    logic                         done_we;
    logic                         is_push, is_pop, is_peek, is_clear;
    logic                         pend_full, done_full, done_empty;
    logic                         desc_hit;
    logic [ddq_pkg::STATUS_W-1:0] check_st;
    logic [ddq_pkg::STATUS_W-1:0] resp_st;
    logic                         out_free;

    assign is_push  = (req_reg == ddq_pkg::REQ_PUSH);
    assign is_pop   = (req_reg == ddq_pkg::REQ_POP);
    assign is_peek  = (req_reg == ddq_pkg::REQ_PEEK);
    assign is_clear = (req_reg == ddq_pkg::REQ_CLEAR);

    assign pend_full  = (pend_count_reg == PCW'(PENDING_DEPTH));
    assign done_full  = (done_count_reg == DCW'(DONE_DEPTH));
    assign done_empty = (done_count_reg == '0);
    assign desc_hit   = (is_pop || is_peek) && !done_empty;
    assign out_free   = !m_valid_reg || out_ready_in;

    assign sts.in_valid  = in_valid;
    assign sts.is_fill   = (req_reg == ddq_pkg::REQ_FILL);
    assign sts.fill_done = (pend_count_reg == '0) || done_full;
    assign sts.out_free  = out_free;

    // Push checks in priority order; the range test avoids a wrapping sum.
    always_comb begin
        if (pend_full) begin
            check_st = ddq_pkg::STAT_PEND_FULL;
        end else if (size_reg == '0) begin
            check_st = ddq_pkg::STAT_SIZE_ZERO;
        end else if (size_reg[ddq_pkg::PAGE_GRAN_BITS-1:0] != '0) begin
            check_st = ddq_pkg::STAT_SIZE_GRAN;
        end else if (size_reg > buf_size_reg || off_reg > (buf_size_reg - size_reg)) begin
            check_st = ddq_pkg::STAT_RANGE;
        end else if (off_reg[ddq_pkg::ALIGN_BITS-1:0] != '0) begin
            check_st = ddq_pkg::STAT_ALIGN;
        end else begin
            check_st = ddq_pkg::STAT_OK;
        end
    end

    always_comb begin
        if (is_push) begin
            resp_st = push_st_reg;
        end else if ((is_pop || is_peek) && done_empty) begin
            resp_st = ddq_pkg::STAT_EMPTY;
        end else begin
            resp_st = ddq_pkg::STAT_OK;
        end
    end

    always_comb begin
        pend_head_next  = pend_head_reg;
        pend_tail_next  = pend_tail_reg;
        pend_count_next = pend_count_reg;
        done_head_next  = done_head_reg;
        done_tail_next  = done_tail_reg;
        done_count_next = done_count_reg;
        push_st_next    = push_st_reg;
        pend_we         = 1'b0;
        done_we         = 1'b0;
        m_valid_next    = m_valid_reg && !out_ready_in;

        if (cmd.exec) begin
            if (is_push) begin
                push_st_next = check_st;
                if (check_st == ddq_pkg::STAT_OK) begin
                    pend_we         = 1'b1;
                    pend_tail_next  = (pend_tail_reg == PAW'(PENDING_DEPTH - 1)) ?
                                      '0 : pend_tail_reg + 1'b1;
                    pend_count_next = pend_count_reg + 1'b1;
                end
            end else if (is_clear) begin
                pend_head_next  = '0;
                pend_tail_next  = '0;
                pend_count_next = '0;
                done_head_next  = '0;
                done_tail_next  = '0;
                done_count_next = '0;
            end
        end

        if (cmd.fill_step) begin
            done_we         = 1'b1;
            pend_head_next  = (pend_head_reg == PAW'(PENDING_DEPTH - 1)) ?
                              '0 : pend_head_reg + 1'b1;
            pend_count_next = pend_count_reg - 1'b1;
            done_tail_next  = (done_tail_reg == DAW'(DONE_DEPTH - 1)) ?
                              '0 : done_tail_reg + 1'b1;
            done_count_next = done_count_reg + 1'b1;
        end

        if (cmd.respond) begin
            m_valid_next = 1'b1;
            if (is_pop && !done_empty) begin
                done_head_next  = (done_head_reg == DAW'(DONE_DEPTH - 1)) ?
                                  '0 : done_head_reg + 1'b1;
                done_count_next = done_count_reg - 1'b1;
            end
        end
    end

    // Read ports are addressed by the next head, so each read register follows
    // every pointer move; data from a memory write is read back once it has landed.
    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pend_mem[pend_tail_reg] <= {size_reg, off_reg};
        end
        pend_rd_reg <= pend_mem[pend_head_next];
    end

    always_ff @(posedge aclk) begin
        if (done_we) begin
            done_mem[done_tail_reg] <= pend_rd_reg;
        end
        done_rd_reg <= done_mem[done_head_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_size_reg   <= '0;
            pend_head_reg  <= '0;
            pend_tail_reg  <= '0;
            pend_count_reg <= '0;
            done_head_reg  <= '0;
            done_tail_reg  <= '0;
            done_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                buf_size_reg <= cfg_wdata;
            end
            pend_head_reg  <= pend_head_next;
            pend_tail_reg  <= pend_tail_next;
            pend_count_reg <= pend_count_next;
            done_head_reg  <= done_head_next;
            done_tail_reg  <= done_tail_next;
            done_count_reg <= done_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        push_st_reg <= push_st_next;
        if (cmd.capture) begin
            req_reg  <= in_req;
            off_reg  <= in_offset;
            size_reg <= in_size;
        end
        if (cmd.respond) begin
            m_status_reg     <= resp_st;
            m_offset_reg     <= desc_hit ? done_rd_reg[A-1:0] : '0;
            m_size_reg       <= desc_hit ? done_rd_reg[2*A-1:A] : '0;
            m_desc_ready_reg <= desc_hit;
            m_free_reg       <= PCW'(PENDING_DEPTH) - pend_count_next;
            m_count_reg      <= done_count_next;
        end
    end

    assign out_valid         = m_valid_reg;
    assign out_status        = m_status_reg;
    assign out_offset        = m_offset_reg;
    assign out_size          = m_size_reg;
    assign out_desc_ready    = m_desc_ready_reg;
    assign out_transfer_free = m_free_reg;
    assign out_ready_count   = m_count_reg;

endmodule
`default_nettype wire

[hw/rtl/dma_descriptor_queue_pair.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA descriptor queue pair
// Pending and done descriptor FIFOs with push validation, fill, pop and peek.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: req_type; tdata: page_offset, page_size
//   m_axis    out        tuser: status; tdata: descriptor, free slots, count
//   cfg       in         buffer_size write
//
// Push, pop, peek, clear and unknown requests pass through the execute and
// response states; a fill adds a fill state that moves descriptors one at a
// time, as the done memory has a single write port.
// Reset clears the queue pointers, counts and buffer_size; memory contents are
// left as they are. A word is accepted while the previous result still waits,
// and the next result then holds until m_axis_tready frees the register.
// ----------------------------------------------------------------------------
module dma_descriptor_queue_pair #(
    parameter int PENDING_DEPTH  = 16,
    parameter int DONE_DEPTH     = 32,
    parameter int BYTE_ADDR_BITS = 36
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // page_offset, page_size
    input  wire logic [((2 * BYTE_ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // req_type
    input  wire logic [ddq_pkg::REQ_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // out_offset, out_size, out_received, out_ready, transfer_free, ready_count
    output logic [((3 * BYTE_ADDR_BITS + 1 + $clog2(PENDING_DEPTH + 1)
                    + $clog2(DONE_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // status
    output logic [ddq_pkg::STATUS_W-1:0]      m_axis_tuser,
    input  wire logic                         cfg_we,
    input  wire logic [BYTE_ADDR_BITS-1:0]    cfg_wdata
);

    localparam int A           = BYTE_ADDR_BITS;
    localparam int PCW         = $clog2(PENDING_DEPTH + 1);
    localparam int DCW         = $clog2(DONE_DEPTH + 1);
    localparam int OUT_BITS    = 3 * A + 1 + PCW + DCW;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    ddq_pkg::ctrl_cmd_t cmd;
    ddq_pkg::ctrl_sts_t sts;

    logic [A-1:0]   res_offset;
    logic [A-1:0]   res_size;
    logic           res_desc_ready;
    logic [PCW-1:0] res_free;
    logic [DCW-1:0] res_count;

    ddq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    ddq_datapath #(
        .PENDING_DEPTH  (PENDING_DEPTH),
        .DONE_DEPTH     (DONE_DEPTH),
        .BYTE_ADDR_BITS (BYTE_ADDR_BITS),
        .PCW            (PCW),
        .DCW            (DCW)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .in_valid          (s_axis_tvalid),
        .in_req            (s_axis_tuser),
        .in_offset         (s_axis_tdata[A-1:0]),
        .in_size           (s_axis_tdata[2*A-1:A]),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .out_valid         (m_axis_tvalid),
        .out_ready_in      (m_axis_tready),
        .out_status        (m_axis_tuser),
        .out_offset        (res_offset),
        .out_size          (res_size),
        .out_desc_ready    (res_desc_ready),
        .out_transfer_free (res_free),
        .out_ready_count   (res_count)
    );

    // Every moved descriptor is received in full, so received equals size.
    assign m_axis_tdata = OUT_TDATA_W'(OUT_BITS'({res_count, res_free, res_desc_ready,
                                                  res_size, res_size, res_offset}));

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DMA descriptor queue pair testbench
// Streams push, pop, peek, fill, clear and unknown request words into the
// block under several buffer sizes, predicts every result word from a local
// copy of both descriptor FIFOs and compares each field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ADDR_W     = 36;
    localparam int REQ_BITS   = ddq_pkg::REQ_W;
    localparam int STAT_BITS  = ddq_pkg::STATUS_W;
    localparam int PEND_DEPTH = 16;
    localparam int DONE_DEPTH = 32;
    localparam int IN_W       = ((2 * ADDR_W + 7) / 8) * 8;
    localparam int OUT_W      = ((3 * ADDR_W + 1 + 5 + 6 + 7) / 8) * 8;
    localparam int RDY_BIT    = 3 * ADDR_W;
    localparam int FREE_LSB   = RDY_BIT + 1;
    localparam int CNT_LSB    = FREE_LSB + 5;
    localparam int STALL_LIMIT = 4000;
    localparam int WORK_SLOTS = 4096;
    localparam int DUE_SLOTS  = 16;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef enum logic [1:0] {
        ACT_WORD,
        ACT_CFG,
        ACT_DRAIN
    } act_kind_t;

    typedef struct {
        act_kind_t            kind;
        logic [REQ_BITS-1:0]  req;
        logic [ADDR_W-1:0]    off;
        logic [ADDR_W-1:0]    size;
    } work_t;

    typedef struct {
        logic [STAT_BITS-1:0] status;
        logic [ADDR_W-1:0]    off;
        logic [ADDR_W-1:0]    size;
        logic [ADDR_W-1:0]    received;
        logic                 ready;
        logic [4:0]           free_slots;
        logic [5:0]           done_level;
    } reply_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // page_offset, page_size
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    // req_type
    logic [REQ_BITS-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // out_offset, out_size, out_received, out_ready, transfer_free, ready_count
    logic [OUT_W-1:0]     m_axis_tdata;
    // status
    logic [STAT_BITS-1:0] m_axis_tuser;
    logic                 cfg_we        = 1'b0;
    logic [ADDR_W-1:0]    cfg_wdata     = '0;

    dma_descriptor_queue_pair dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Local copy of the block's state.
    logic [ADDR_W-1:0] buffer_bytes;
    logic [ADDR_W-1:0] pend_off [PEND_DEPTH];
    logic [ADDR_W-1:0] pend_size[PEND_DEPTH];
    int                pend_head, pend_count;
    logic [ADDR_W-1:0] done_off [DONE_DEPTH];
    logic [ADDR_W-1:0] done_size[DONE_DEPTH];
    int                done_head, done_count;

    // Pending stimulus and expected results, each read in order by index.
    work_t  work_mem[WORK_SLOTS];
    int     work_rd      = 0;
    int     work_wr      = 0;
    reply_t due_mem[DUE_SLOTS];
    int     due_rd       = 0;
    int     due_wr       = 0;
    int     words_sent   = 0;
    int     words_in     = 0;
    int     reset_cycles = 0;
    int     stall_cycles = 0;
    int     errors       = 0;
    logic   stim_done    = 1'b0;
    logic   calm;

    // The middle of the run has no random idling on either side.
    assign calm = (words_sent >= 700) && (words_sent < 950);

    function automatic reply_t apply_request(logic [REQ_BITS-1:0] req,
                                             logic [ADDR_W-1:0] off,
                                             logic [ADDR_W-1:0] size);
        reply_t r;
        int     slot;
        r = '{status: ddq_pkg::STAT_OK, off: '0, size: '0, received: '0, ready: 1'b0,
              free_slots: '0, done_level: '0};
        case (req)
            ddq_pkg::REQ_PUSH: begin
                // Checks run in a fixed order; the range test avoids overflow.
                if (pend_count >= PEND_DEPTH) r.status = ddq_pkg::STAT_PEND_FULL;
                else if (size == '0) r.status = ddq_pkg::STAT_SIZE_ZERO;
                else if (size[ddq_pkg::PAGE_GRAN_BITS-1:0] != '0)
                    r.status = ddq_pkg::STAT_SIZE_GRAN;
                else if (size > buffer_bytes || off > buffer_bytes - size)
                    r.status = ddq_pkg::STAT_RANGE;
                else if (off[ddq_pkg::ALIGN_BITS-1:0] != '0) r.status = ddq_pkg::STAT_ALIGN;
                else begin
                    slot = (pend_head + pend_count) % PEND_DEPTH;
                    pend_off[slot]  = off;
                    pend_size[slot] = size;
                    pend_count++;
                end
            end
            ddq_pkg::REQ_POP, ddq_pkg::REQ_PEEK: begin
                if (done_count == 0) begin
                    r.status = ddq_pkg::STAT_EMPTY;
                end else begin
                    r.off      = done_off[done_head];
                    r.size     = done_size[done_head];
                    r.received = done_size[done_head];
                    r.ready    = 1'b1;
                    if (req == ddq_pkg::REQ_POP) begin
                        done_head = (done_head + 1) % DONE_DEPTH;
                        done_count--;
                    end
                end
            end
            ddq_pkg::REQ_FILL: begin
                while (pend_count > 0 && done_count < DONE_DEPTH) begin
                    slot = (done_head + done_count) % DONE_DEPTH;
                    done_off[slot]  = pend_off[pend_head];
                    done_size[slot] = pend_size[pend_head];
                    done_count++;
                    pend_head = (pend_head + 1) % PEND_DEPTH;
                    pend_count--;
                end
            end
            ddq_pkg::REQ_CLEAR: begin
                pend_head  = 0;
                pend_count = 0;
                done_head  = 0;
                done_count = 0;
            end
            default: ;
        endcase
        r.free_slots = 5'(PEND_DEPTH - pend_count);
        r.done_level = 6'(done_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] seen);
        if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
        end
    endtask

    // Driver: reset, then words and register writes from the work list.
    always @(negedge aclk) begin
        work_t w;
        logic  next_valid;
        logic  next_we;
        next_valid = s_axis_tvalid;
        next_we    = 1'b0;
        if (reset_cycles < 2) begin
            reset_cycles <= reset_cycles + 1;
            aresetn      <= 1'b0;
            next_valid   = 1'b0;
        end else begin
            aresetn <= 1'b1;
            if (s_axis_tvalid && words_in != words_sent) begin
                // The word on the bus has not been taken yet.
            end else begin
                next_valid = 1'b0;
                if (work_rd == work_wr) begin
                    stim_done <= 1'b1;
                end else begin
                    w = work_mem[work_rd];
                    case (w.kind)
                        ACT_WORD: begin
                            if (calm || $urandom_range(99) >= 37) begin
                                s_axis_tuser <= w.req;
                                s_axis_tdata <= {w.size, w.off};
                                next_valid   = 1'b1;
                                words_sent   <= words_sent + 1;
                                work_rd++;
                            end
                        end
                        ACT_CFG: begin
                            if (due_wr == due_rd) begin
                                cfg_wdata <= w.off;
                                next_we   = 1'b1;
                                work_rd++;
                            end
                        end
                        default: begin
                            if (due_wr == due_rd) work_rd++;
                        end
                    endcase
                end
            end
        end
        s_axis_tvalid <= next_valid;
        cfg_we        <= next_we;
        m_axis_tready <= calm || ($urandom_range(99) >= 37);
    end

    // Monitor: predicts on accepted input words, checks accepted result words.
    always @(posedge aclk) begin
        reply_t want;
        logic   moved;
        if (!aresetn) begin
            buffer_bytes = '0;
            pend_head    = 0;
            pend_count   = 0;
            done_head    = 0;
            done_count   = 0;
        end else begin
            moved = cfg_we;
            if (cfg_we) buffer_bytes = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1'b1;
                due_mem[due_wr % DUE_SLOTS] = apply_request(s_axis_tuser,
                                                            s_axis_tdata[ADDR_W-1:0],
                                                            s_axis_tdata[2*ADDR_W-1:ADDR_W]);
                due_wr++;
                words_in <= words_in + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (due_wr == due_rd) begin
                    $error("result word with no request outstanding");
                    errors++;
                end else begin
                    want = due_mem[due_rd % DUE_SLOTS];
                    due_rd++;
                    check_field("status", ADDR_W'(want.status), ADDR_W'(m_axis_tuser));
                    check_field("out_offset", want.off, m_axis_tdata[ADDR_W-1:0]);
                    check_field("out_size", want.size, m_axis_tdata[2*ADDR_W-1:ADDR_W]);
                    check_field("out_received", want.received,
                                m_axis_tdata[3*ADDR_W-1:2*ADDR_W]);
                    check_field("out_ready", ADDR_W'(want.ready),
                                ADDR_W'(m_axis_tdata[RDY_BIT]));
                    check_field("transfer_free", ADDR_W'(want.free_slots),
                                ADDR_W'(m_axis_tdata[FREE_LSB+4:FREE_LSB]));
                    check_field("ready_count", ADDR_W'(want.done_level),
                                ADDR_W'(m_axis_tdata[CNT_LSB+5:CNT_LSB]));
                end
            end
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand36();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    task automatic enqueue_work(work_t w);
        work_mem[work_wr] = w;
        work_wr++;
    endtask

    task automatic add_word(logic [REQ_BITS-1:0] req, logic [ADDR_W-1:0] off,
                            logic [ADDR_W-1:0] size);
        enqueue_work('{kind: ACT_WORD, req: req, off: off, size: size});
    endtask

    task automatic add_cfg(logic [ADDR_W-1:0] value);
        enqueue_work('{kind: ACT_CFG, req: ddq_pkg::REQ_PUSH, off: value, size: '0});
    endtask

    // A descriptor that passes every check for the given buffer size, where one exists.
    task automatic make_push(input logic [ADDR_W-1:0] buf_len, output logic [ADDR_W-1:0] off,
                             output logic [ADDR_W-1:0] size);
        logic [63:0] pages, k, room, r;
        pages = {28'd0, buf_len} >> ddq_pkg::PAGE_GRAN_BITS;
        r     = {$urandom, $urandom};
        if (pages == 0) k = 64'($urandom_range(1, 3));
        else if ($urandom_range(9) == 0) k = 1 + r % pages;
        else k = 64'($urandom_range(1, (pages < 8) ? int'(pages) : 8));
        size = ADDR_W'(k << ddq_pkg::PAGE_GRAN_BITS);
        if (size > buf_len) begin
            off = rand36() & ~36'h3;
        end else begin
            room = {28'd0, buf_len - size};
            r    = {$urandom, $urandom};
            if ($urandom_range(7) == 0) off = ADDR_W'(room) & ~36'h3;
            else off = ADDR_W'(r % (room + 1)) & ~36'h3;
        end
    endtask

    task automatic add_random(logic heavy, logic [ADDR_W-1:0] buf_len);
        int                roll;
        logic [ADDR_W-1:0] off, size;
        roll = $urandom_range(99);
        make_push(buf_len, off, size);
        if (roll < (heavy ? 60 : 40)) add_word(ddq_pkg::REQ_PUSH, off, size);
        else if (roll < (heavy ? 64 : 55)) add_word(ddq_pkg::REQ_FILL, rand36(), rand36());
        else if (roll < (heavy ? 76 : 77)) add_word(ddq_pkg::REQ_POP, rand36(), rand36());
        else if (roll < (heavy ? 83 : 85)) add_word(ddq_pkg::REQ_PEEK, rand36(), rand36());
        else if (roll < (heavy ? 85 : 87)) add_word(ddq_pkg::REQ_CLEAR, rand36(), rand36());
        else begin
            // Noise: arbitrary words and pushes broken in one way.
            case ($urandom_range(4))
                0: add_word(REQ_BITS'($urandom_range(7)), rand36(), rand36());
                1: add_word(ddq_pkg::REQ_PUSH, off, '0);
                2: add_word(ddq_pkg::REQ_PUSH, off,
                            size | ADDR_W'($urandom_range(1, 32767)));
                3: add_word(ddq_pkg::REQ_PUSH, off | ADDR_W'($urandom_range(1, 3)), size);
                default: add_word(ddq_pkg::REQ_PUSH,
                                  buf_len - size + ADDR_W'(4 * $urandom_range(1, 4)), size);
            endcase
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] settings[6];

        // Directed words: every check but a full pending queue, both empty replies, unknown requests, full bounds.
        add_cfg('0);
        add_word(ddq_pkg::REQ_PUSH, '0, 36'h000008000);
        add_word(ddq_pkg::REQ_POP, '0, '0);
        add_word(ddq_pkg::REQ_PEEK, '0, '0);
        add_word(3'd5, ADDR_MAX, ADDR_MAX);
        add_word(3'd6, ADDR_MAX, ADDR_MAX);
        add_word(3'd7, ADDR_MAX, ADDR_MAX);
        add_cfg(ADDR_MAX);
        add_word(ddq_pkg::REQ_PUSH, '0, '0);
        add_word(ddq_pkg::REQ_PUSH, '0, 36'h000008001);
        add_word(ddq_pkg::REQ_PUSH, '0, ADDR_MAX);
        add_word(ddq_pkg::REQ_PUSH, '0, 36'h000008000);
        add_word(ddq_pkg::REQ_PUSH, 36'h000000002, 36'h000008000);
        add_word(ddq_pkg::REQ_PUSH, ADDR_MAX, 36'h000008000);
        add_word(ddq_pkg::REQ_PUSH, 36'hFFFFF7FFC, 36'h000008000);
        add_word(ddq_pkg::REQ_PUSH, '0, 36'hFFFFF8000);
        add_word(ddq_pkg::REQ_PUSH, 36'h000008000, 36'hFFFFF8000);
        add_word(ddq_pkg::REQ_PUSH, 36'h000000001, 36'h000010000);
        add_word(ddq_pkg::REQ_PEEK, '0, '0);
        add_word(ddq_pkg::REQ_FILL, '0, '0);
        add_word(ddq_pkg::REQ_PEEK, '0, '0);
        add_word(ddq_pkg::REQ_POP, '0, '0);
        add_word(ddq_pkg::REQ_POP, '0, '0);
        add_word(ddq_pkg::REQ_PUSH, 36'h000010000, 36'h000008000);
        add_word(ddq_pkg::REQ_CLEAR, '0, '0);
        add_word(ddq_pkg::REQ_POP, '0, '0);

        settings = '{ADDR_MAX, '0, 36'h000100000, rand36(), 36'h000008000, rand36()};
        foreach (settings[p]) begin
            add_cfg(settings[p]);
            for (int i = 0; i < 250; i++) begin
                // Hold the sender once until every result is back.
                if (p == 2 && i == 125)
                    enqueue_work('{kind: ACT_DRAIN, req: ddq_pkg::REQ_PUSH, off: '0,
                                   size: '0});
                add_random(p == 0 || p == 3 || p == 5, settings[p]);
            end
        end

        do @(posedge aclk); while (!(stim_done && due_wr == due_rd));
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
